FILE: hw/rtl/psa_pkg.sv
// Shared constants, codes and control structs of the partition slot allocator.
`default_nettype none

package psa_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [31:0] TABLE_BASE = 32'd512;

    localparam int BYTE_W = 31;
    localparam int NAME_W = 64;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_EXT     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;
    localparam logic [2:0] ST_SPACE   = 3'd5;

    // partition kinds and fit modes
    localparam logic [1:0] KIND_EXTENDED = 2'd1;
    localparam logic [1:0] KIND_LOGICAL  = 2'd2;
    localparam logic [1:0] FIT_WORST     = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic place;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic chk_fail;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/psa_ifs.sv
// Valid/ready channel interfaces for create requests and results.
`default_nettype none

interface psa_req_if;
    logic                          valid;
    logic                          ready;
    logic [psa_pkg::BYTE_W-1:0]    size_count;
    logic                          unit_is_mega;
    logic [1:0]                    part_kind;
    logic [1:0]                    fit_mode;
    logic [psa_pkg::NAME_W-1:0]    name_key;

    modport source (output valid, size_count, unit_is_mega, part_kind, fit_mode, name_key,
                    input ready);
    modport sink   (input valid, size_count, unit_is_mega, part_kind, fit_mode, name_key,
                    output ready);
endinterface

interface psa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [1:0]                    slot_index;
    logic [psa_pkg::BYTE_W-1:0]    start_byte;
    logic [psa_pkg::BYTE_W-1:0]    size_bytes;

    modport source (output valid, status, slot_index, start_byte, size_bytes,
                    input ready);
    modport sink   (input valid, status, slot_index, start_byte, size_bytes,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psa_ctrl.sv
// Sequencer of the partition slot allocator: check, gap scan, place.
`default_nettype none

module psa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire psa_pkg::t_stat i_stat,
    output psa_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_PLACE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.chk_fail ? S_PLACE : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                // wait for room in the output register
                if (i_stat.out_free) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/psa_dp.sv
// Datapath: request registers, slot table, ordering ranks, gap scan, result register.
`default_nettype none

module psa_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire psa_pkg::t_cmd              i_cmd,
    output psa_pkg::t_stat                  o_stat,
    input  wire logic                       i_cfg_we,
    input  wire logic [psa_pkg::BYTE_W-1:0] i_cfg_data,
    input  wire logic [psa_pkg::BYTE_W-1:0] i_size_count,
    input  wire logic                       i_unit_is_mega,
    input  wire logic [1:0]                 i_part_kind,
    input  wire logic [1:0]                 i_fit_mode,
    input  wire logic [psa_pkg::NAME_W-1:0] i_name_key,
    output logic                            o_rsp_valid,
    input  wire logic                       i_rsp_ready,
    output logic [2:0]                      o_status,
    output logic [1:0]                      o_slot_index,
    output logic [psa_pkg::BYTE_W-1:0]      o_start_byte,
    output logic [psa_pkg::BYTE_W-1:0]      o_size_bytes
);

    localparam int N   = psa_pkg::SLOT_COUNT;
    localparam int IW  = psa_pkg::SLOT_IW;
    localparam int CW  = psa_pkg::CNT_W;
    localparam int BW  = psa_pkg::BYTE_W;
    localparam int NW  = psa_pkg::NAME_W;

    // configuration and table
    logic [BW-1:0] r_disk;
    logic [BW-1:0] r_slot_start [N];
    logic [BW-1:0] r_slot_size  [N];
    logic [1:0]    r_slot_kind  [N];
    logic [1:0]    r_slot_fit   [N];
    logic [NW-1:0] r_slot_name  [N];

    // request
    logic [BW-1:0] r_count;
    logic          r_mega;
    logic [1:0]    r_kind;
    logic [1:0]    r_fit;
    logic [NW-1:0] r_key;

    // working state
    logic [2:0]    r_status;
    logic [IW-1:0] r_free_slot;
    logic [CW-1:0] r_rank [N];
    logic [CW-1:0] r_used_cnt;
    logic [CW-1:0] r_step;
    logic [31:0]   r_cur;

    // result register
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [1:0]    r_out_slot;
    logic [BW-1:0] r_out_start;
    logic [BW-1:0] r_out_size;

    logic          w_big;
    logic [BW-1:0] w_raw;
    logic [31:0]   w_bytes;
    logic [32:0]   w_end;

    logic [N-1:0]  w_used;
    logic          w_invalid;
    logic          w_dup;
    logic          w_ext;
    logic          w_found;
    logic [IW-1:0] w_free_slot;
    logic [2:0]    w_chk_status;
    logic [CW-1:0] w_rank [N];
    logic [CW-1:0] w_used_cnt;

    logic [BW-1:0] w_seg_start;
    logic [BW-1:0] w_seg_size;
    logic [31:0]   w_seg_end;
    logic          w_fits;
    logic          w_scan_done;

    logic          w_space;
    logic [2:0]    w_final;
    logic          w_ok;
    logic [IW+1:0] w_slot_ext;

    // byte size, saturated at 2^31: anything that large never fits
    always_comb begin
        if (r_mega) begin
            w_big = |r_count[BW-1:11];
            w_raw = {r_count[10:0], 20'd0};
        end else begin
            w_big = |r_count[BW-1:21];
            w_raw = {r_count[20:0], 10'd0};
        end
        w_bytes = w_big ? 32'h8000_0000 : {1'b0, w_raw};
        w_end   = {1'b0, r_cur} + {1'b0, w_bytes};
    end

    // request checks against the table
    always_comb begin
        w_invalid = (r_count == '0) || (r_key == '0) ||
                    (r_kind > psa_pkg::KIND_LOGICAL) || (r_fit > psa_pkg::FIT_WORST);
        w_dup       = 1'b0;
        w_ext       = 1'b0;
        w_found     = 1'b0;
        w_free_slot = '0;
        w_used_cnt  = '0;
        for (int i = 0; i < N; i++) begin
            w_used[i] = (r_slot_size[i] != '0);
            if (r_slot_name[i] == r_key) begin
                w_dup = 1'b1;
            end
            if (w_used[i] && (r_slot_kind[i] == psa_pkg::KIND_EXTENDED)) begin
                w_ext = 1'b1;
            end
            if (w_used[i]) begin
                w_used_cnt = w_used_cnt + CW'(1);
            end
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (!w_used[i]) begin
                w_found     = 1'b1;
                w_free_slot = IW'(i);
            end
        end
        if (w_invalid) begin
            w_chk_status = psa_pkg::ST_INVALID;
        end else if (w_dup) begin
            w_chk_status = psa_pkg::ST_DUP;
        end else if (w_ext && (r_kind == psa_pkg::KIND_EXTENDED)) begin
            w_chk_status = psa_pkg::ST_EXT;
        end else if (!w_found) begin
            w_chk_status = psa_pkg::ST_FULL;
        end else begin
            w_chk_status = psa_pkg::ST_OK;
        end
    end

    // rank of each used slot in (start, size) order, slot number breaks ties
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < N; j++) begin
                if (w_used[i] && w_used[j] && (j != i) &&
                    ((r_slot_start[j] < r_slot_start[i]) ||
                     ((r_slot_start[j] == r_slot_start[i]) &&
                      ((r_slot_size[j] < r_slot_size[i]) ||
                       ((r_slot_size[j] == r_slot_size[i]) && (j < i)))))) begin
                    w_rank[i] = w_rank[i] + CW'(1);
                end
            end
        end
    end

    // one used segment per scan step
    always_comb begin
        w_seg_start = '0;
        w_seg_size  = '0;
        for (int i = 0; i < N; i++) begin
            if (w_used[i] && (r_rank[i] == r_step)) begin
                w_seg_start = r_slot_start[i];
                w_seg_size  = r_slot_size[i];
            end
        end
        w_seg_end   = {1'b0, w_seg_start} + {1'b0, w_seg_size};
        w_fits      = (w_end <= {2'b00, w_seg_start});
        w_scan_done = (r_step == r_used_cnt) || w_fits;
    end

    always_comb begin
        w_space = (w_end > {2'b00, r_disk});
        if (r_status != psa_pkg::ST_OK) begin
            w_final = r_status;
        end else if (w_space) begin
            w_final = psa_pkg::ST_SPACE;
        end else begin
            w_final = psa_pkg::ST_OK;
        end
        w_ok       = (w_final == psa_pkg::ST_OK);
        w_slot_ext = {2'b00, r_free_slot};
    end

    assign o_stat.chk_fail  = (w_chk_status != psa_pkg::ST_OK);
    assign o_stat.scan_done = w_scan_done;
    assign o_stat.out_free  = !r_out_valid || i_rsp_ready;

    // control state and table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_slot_start[i] <= '0;
                r_slot_size[i]  <= '0;
                r_slot_kind[i]  <= '0;
                r_slot_fit[i]   <= '0;
                r_slot_name[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_disk <= i_cfg_data;
            end
            if (i_cmd.place) begin
                r_out_valid <= 1'b1;
                if (w_ok) begin
                    r_slot_start[r_free_slot] <= r_cur[BW-1:0];
                    r_slot_size[r_free_slot]  <= w_bytes[BW-1:0];
                    r_slot_kind[r_free_slot]  <= r_kind;
                    r_slot_fit[r_free_slot]   <= r_fit;
                    r_slot_name[r_free_slot]  <= r_key;
                end
            end else if (r_out_valid && i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= i_size_count;
            r_mega  <= i_unit_is_mega;
            r_kind  <= i_part_kind;
            r_fit   <= i_fit_mode;
            r_key   <= i_name_key;
        end
        if (i_cmd.check) begin
            r_status    <= w_chk_status;
            r_free_slot <= w_free_slot;
            r_used_cnt  <= w_used_cnt;
            r_step      <= '0;
            r_cur       <= psa_pkg::TABLE_BASE;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= w_rank[i];
            end
        end
        if (i_cmd.scan && !w_scan_done) begin
            r_cur  <= w_seg_end;
            r_step <= r_step + CW'(1);
        end
        if (i_cmd.place) begin
            r_out_status <= w_final;
            r_out_slot   <= w_ok ? w_slot_ext[1:0] : 2'd0;
            r_out_start  <= w_ok ? r_cur[BW-1:0] : '0;
            r_out_size   <= w_ok ? w_bytes[BW-1:0] : '0;
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;
    assign o_start_byte = r_out_start;
    assign o_size_bytes = r_out_size;

endmodule

`default_nettype wire

FILE: hw/rtl/partition_slot_allocator_top.sv
// Top level of the partition slot allocator: first-fit placement into a slot table.
//
// Usage:
//   i_req  - create request channel (valid/ready). A transfer takes size_count,
//            unit_is_mega, part_kind, fit_mode and name_key.
//   o_rsp  - result channel (valid/ready), one transfer per request: status,
//            slot_index, start_byte, size_bytes. Rejected requests return zeros
//            in the last three fields and leave the table untouched.
//   i_cfg_we / i_cfg_data - writes the disk size in bytes; write only while idle.
// Sequence: a request failing the table checks goes from the check step to the
//   place step; one that reaches the gap scan (placed or out of space) walks the
//   used slots in order until a gap or the end, then goes to the place step.
// Throughput: one request at a time; the gap scan visits one used slot per cycle
//   in order of (start, size).
// Reset (synchronous, active low) empties every slot and sets the disk size
//   to zero.
// Stall: the result sits in an output register; the next request is taken
//   while it waits, and a finished request holds in the place step until that
//   register is free.
`default_nettype none

module partition_slot_allocator_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    psa_req_if.sink                         i_req,
    psa_rsp_if.source                       o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic [psa_pkg::BYTE_W-1:0] i_cfg_data
);

    psa_pkg::t_cmd  w_cmd;
    psa_pkg::t_stat w_stat;
    logic           w_in_ready;

    // sequencer: idle -> check -> scan -> place; a failed check goes straight to place
    psa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_req.ready = w_in_ready;

    // table, checks, gap scan and result register
    psa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_size_count   (i_req.size_count),
        .i_unit_is_mega (i_req.unit_is_mega),
        .i_part_kind    (i_req.part_kind),
        .i_fit_mode     (i_req.fit_mode),
        .i_name_key     (i_req.name_key),
        .o_rsp_valid    (o_rsp.valid),
        .i_rsp_ready    (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_slot_index   (o_rsp.slot_index),
        .o_start_byte   (o_rsp.start_byte),
        .o_size_bytes   (o_rsp.size_bytes)
    );

endmodule

`default_nettype wire
